@@ hdl/lpht_pkg.sv @@
// Shared constants and types for the linear-probing hash table.
package lpht_pkg;

  // Table geometry. SLOTS must stay a power of two so the slot index wraps.
  localparam int IDX_W      = 10;
  localparam int SLOTS      = 1 << IDX_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // One slot of the table memory
  typedef struct packed {
    logic                  used;
    logic [IDX_W-1:0]      home;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

endpackage

@@ hdl/linear_probe_hash_table.sv @@
// Top level: open-addressing key/value table with linear probing.
//
//  channel   signals                                 direction
//  request   in_valid, in_stall, mode, key,          in (in_stall out)
//            key_hash, value
//  result    out_valid, out_stall, status,           out (out_stall in)
//            found_value, slot_index, entry_count
//
// Insert and lookup read the home slot on accept, then probe slot by slot
// from home. Remove does the lookup probes, then scans the run behind the hole
// for the backward shift, then frees the hole; the slot memory, with one read
// and one write port, sets the pace. Reset and clear sweep the memory, one
// slot a cycle; no request is accepted during the sweep after reset.
// A finished request holds in the done state while the output register is
// stalled; the block takes no new request until that result moves out.
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [31:0]           key_hash,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [31:0]           found_value,
  output logic [IDX_W-1:0]      slot_index,
  output logic [CNT_W-1:0]      entry_count
);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_PROBE, S_SHIFT, S_FREE, S_DONE
  } state_t;

  state_t                state;
  logic                  clr_req;
  logic [1:0]            req_mode;
  logic [KEY_BITS-1:0]   req_key;
  logic [IDX_W-1:0]      req_home;
  logic [VALUE_BITS-1:0] req_value;
  logic [IDX_W-1:0]      probe;
  logic [IDX_W-1:0]      step;
  logic [IDX_W-1:0]      hole;
  logic [CNT_W-1:0]      cnt;
  logic [1:0]            res_status;
  logic [31:0]           res_value;
  logic [IDX_W-1:0]      res_slot;

  slot_t                 mem [SLOTS];
  slot_t                 rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  slot_t                 wr_data;
  logic                  hit;
  logic                  keep;

  // True when h lies cyclically in (lo, hi]
  function automatic logic in_cyclic(input logic [IDX_W-1:0] lo,
                                     input logic [IDX_W-1:0] h,
                                     input logic [IDX_W-1:0] hi);
    if (lo <= hi) return (lo < h) && (h <= hi);
    return (lo < h) || (h <= hi);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign hit  = rd_data.used && (rd_data.home == req_home) && (rd_data.key == req_key);
  assign keep = in_cyclic(hole, rd_data.home, probe);

  // Read the home slot on accept, else the slot after the current probe
  assign rd_addr = (state == S_IDLE) ? key_hash[IDX_W-1:0] : probe + 1'b1;

  // Select the memory write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = probe;
    wr_data = '0;
    case (state)
      S_SWEEP: begin
        wr_en = 1'b1;
      end
      S_PROBE: begin
        if (req_mode == MODE_INSERT && !rd_data.used) begin
          wr_en   = 1'b1;
          wr_data = '{used: 1'b1, home: req_home, key: req_key, value: req_value};
        end
      end
      S_SHIFT: begin
        if (rd_data.used && !keep) begin
          wr_en   = 1'b1;
          wr_addr = hole;
          wr_data = rd_data;
        end
      end
      S_FREE: begin
        wr_en   = 1'b1;
        wr_addr = hole;
      end
      default: ;
    endcase
  end

  // Slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Sequence requests and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      clr_req   <= 1'b0;
      probe     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_SWEEP: begin
          probe <= probe + 1'b1;
          if (probe == IDX_W'(SLOTS - 1)) begin
            state <= clr_req ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_mode   <= mode;
            req_key    <= key;
            req_home   <= key_hash[IDX_W-1:0];
            req_value  <= value;
            step       <= '0;
            res_value  <= '0;
            res_slot   <= '0;
            case (mode)
              MODE_INSERT: begin
                probe   <= key_hash[IDX_W-1:0];
                clr_req <= 1'b0;
                if (cnt == CNT_W'(SLOTS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_PROBE;
                end
              end
              MODE_LOOKUP, MODE_REMOVE: begin
                probe   <= key_hash[IDX_W-1:0];
                clr_req <= 1'b0;
                if (cnt == '0) begin
                  res_status <= ST_NOTFOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_PROBE;
                end
              end
              default: begin
                // clear: sweep every slot free
                cnt        <= '0;
                probe      <= '0;
                clr_req    <= 1'b1;
                res_status <= ST_OK;
                state      <= S_SWEEP;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (req_mode == MODE_INSERT) begin
            if (!rd_data.used) begin
              cnt      <= cnt + 1'b1;
              res_slot <= probe;
              state    <= S_DONE;
            end else begin
              probe <= probe + 1'b1;
            end
          end else if (!rd_data.used) begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end else if (hit) begin
            res_slot <= probe;
            if (req_mode == MODE_LOOKUP) begin
              res_value <= 32'(rd_data.value);
              state     <= S_DONE;
            end else begin
              // open the hole and scan the run behind it
              hole  <= probe;
              probe <= probe + 1'b1;
              step  <= IDX_W'(1);
              state <= S_SHIFT;
            end
          end else if (step == IDX_W'(SLOTS - 1)) begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end else begin
            probe <= probe + 1'b1;
            step  <= step + 1'b1;
          end
        end
        S_SHIFT: begin
          if (!rd_data.used) begin
            state <= S_FREE;
          end else begin
            // move the entry back into the hole when its home allows
            if (!keep) hole <= probe;
            if (step == IDX_W'(SLOTS - 1)) begin
              state <= S_FREE;
            end else begin
              probe <= probe + 1'b1;
              step  <= step + 1'b1;
            end
          end
        end
        S_FREE: begin
          cnt   <= cnt - 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            found_value <= res_value;
            slot_index  <= res_slot;
            entry_count <= (res_status == ST_OK && clr_req) ? '0 : cnt;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Count never exceeds the table size
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_W'(SLOTS))
    else $error("entry count above table size");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_NOTFOUND || status == ST_FULL))
    else $error("undefined status code");

  // Full is reported only when every slot is used
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> entry_count == CNT_W'(SLOTS))
    else $error("full status with free slots");

  // A miss reports neither a slot nor a value
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOTFOUND) |-> (slot_index == '0 && found_value == '0))
    else $error("miss with slot or value");

  // A removal always frees exactly one slot
  a_free_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE) |=> cnt == $past(cnt) - 1'b1)
    else $error("remove did not drop count");

endmodule
